>>> src/spiq_pkg.sv
// ----------------------------------------------------------------------------
// spiq_pkg
// Shared types and constants for the stable priority insert queue.
// ----------------------------------------------------------------------------
package spiq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PRIO_W    = 3;
  localparam int DATA_W    = 32;
  localparam int WORD_W    = PRIO_W + DATA_W;

  localparam logic [PRIO_W-1:0] PRIO_MAX = 3'd5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  typedef enum logic [1:0] {
    ST_ENTRY   = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // result word control, sequencer -> top level output stage
  typedef struct packed {
    logic    valid;
    status_t status;
    logic    last;
    logic    from_ram;
  } res_ctl_t;

endpackage

>>> src/stable_priority_insert_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_insert_queue_top
// Sorted priority queue with stable insertion and in-order dump.
// ----------------------------------------------------------------------------
// Insert (in_operation 0) keeps busy high while the sequencer walks from the
// tail, one read-compare-write step (S_INS_RD, then S_INS_CMP) per entry it
// looks at, through the one RAM: each stored entry with a higher priority
// than the new one, and then the first one that is not, unless the new entry
// lands at the head. Invalid, full and empty-dump cases keep busy low and
// give one word, with out_last set, in the cycle after the accepting edge. A
// dump keeps busy high while it emits one word per cycle; the first word
// also passes the registered RAM read, so it comes later than a status word
// would, and the last word shows in the cycle after busy falls. out_valid is
// a one-cycle strobe; the receiver must take every word as it comes. The
// store needs no clearing pass after reset: only entries below the fill
// count are ever read.
// ----------------------------------------------------------------------------
module stable_priority_insert_queue_top #(
  parameter int DEPTH = spiq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_operation,
  input  logic [spiq_pkg::PRIO_W-1:0]        in_priority_req,
  input  logic signed [spiq_pkg::DATA_W-1:0] in_payload,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [spiq_pkg::PRIO_W-1:0]        out_entry_priority,
  output logic signed [spiq_pkg::DATA_W-1:0] out_entry_payload,
  output logic                               out_last
);

  import spiq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  res_ctl_t          res;

  spiq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .op     (in_operation),
    .prio   (in_priority_req),
    .data   (DATA_W'(unsigned'(in_payload))),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res    (res)
  );

  spiq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // status words carry zero priority and data
  assign out_valid          = res.valid;
  assign out_status         = res.status;
  assign out_last           = res.last;
  assign out_entry_priority = res.from_ram ? rd_data[WORD_W-1:DATA_W] : '0;
  assign out_entry_payload  = res.from_ram ? signed'(rd_data[DATA_W-1:0]) : '0;

endmodule

>>> src/spiq_ram.sv
// ----------------------------------------------------------------------------
// spiq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/spiq_ctrl.sv
// ----------------------------------------------------------------------------
// spiq_ctrl
// Sequencer: walks the store from the tail with one read-compare-write unit
// for inserts, and streams the store out for dumps.
// ----------------------------------------------------------------------------
module spiq_ctrl #(
  parameter int DEPTH = spiq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [spiq_pkg::PRIO_W-1:0]   prio,
  input  logic [spiq_pkg::DATA_W-1:0]   data,
  output logic                          wr_en,
  output logic [$clog2(DEPTH)-1:0]      wr_addr,
  output logic [spiq_pkg::WORD_W-1:0]   wr_data,
  output logic [$clog2(DEPTH)-1:0]      rd_addr,
  input  logic [spiq_pkg::WORD_W-1:0]   rd_data,
  output spiq_pkg::res_ctl_t            res
);

  import spiq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DUMP
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  res_ctl_t          res_r, res_nxt;

  logic [PRIO_W-1:0] rd_prio;
  logic              moves_up;
  logic [CW-1:0]     idx_dec;

  assign rd_prio  = rd_data[WORD_W-1:DATA_W];
  // shared compare: stored entry ranks strictly after the new one
  assign moves_up = (rd_prio > prio_r);
  assign idx_dec  = idx_r - CW'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    prio_nxt  = prio_r;
    data_nxt  = data_r;
    res_nxt   = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_data   = {prio_r, data_r};
    rd_addr   = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          prio_nxt = prio;
          data_nxt = data;
          if (op == OP_DUMP) begin
            if (cnt_r == '0) begin
              res_nxt = '{valid: 1'b1, status: ST_EMPTY, last: 1'b1, from_ram: 1'b0};
            end else begin
              idx_nxt   = '0;
              state_nxt = S_DUMP;
            end
          end else if (prio > PRIO_MAX) begin
            res_nxt = '{valid: 1'b1, status: ST_INVALID, last: 1'b1, from_ram: 1'b0};
          end else if (cnt_r == FULL_CNT) begin
            res_nxt = '{valid: 1'b1, status: ST_FULL, last: 1'b1, from_ram: 1'b0};
          end else begin
            idx_nxt   = cnt_r;
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_IDLE;
        end else begin
          rd_addr   = idx_dec[AW-1:0];
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (moves_up) begin
          wr_data   = rd_data;
          idx_nxt   = idx_dec;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        res_nxt.valid    = 1'b1;
        res_nxt.status   = ST_ENTRY;
        res_nxt.from_ram = 1'b1;
        res_nxt.last     = (idx_r == cnt_r - CW'(1));
        idx_nxt          = idx_r + CW'(1);
        if (res_nxt.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      res_r   <= res_nxt;
    end
    prio_r <= prio_nxt;
    data_r <= data_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

endmodule

>>> tb/sv/spiq_checker.sv
// ----------------------------------------------------------------------------
// spiq_checker
// Watches the command and result channels of the priority queue, keeps its
// own sorted copy of the store and compares every result word, field by
// field, with the oldest word still due.
// ----------------------------------------------------------------------------
module spiq_checker
  import spiq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_operation,
  input  logic [PRIO_W-1:0]        in_priority_req,
  input  logic signed [DATA_W-1:0] in_payload,
  input  logic                     out_valid,
  input  logic [1:0]               out_status,
  input  logic [PRIO_W-1:0]        out_entry_priority,
  input  logic signed [DATA_W-1:0] out_entry_payload,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t                  status;
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } word_t;

  word_t             due_words[$];
  logic [PRIO_W-1:0] held_prio [DEPTH];
  logic [DATA_W-1:0] held_data [DEPTH];
  int                held_count;
  int                errs;

  assign fail_count = errs;

  initial begin
    errs    = 0;
    pending = 0;
  end

  function automatic void push_word(status_t st, logic [PRIO_W-1:0] pr,
                                    logic [DATA_W-1:0] d, logic lst);
    word_t w;
    w.status = st;
    w.prio   = pr;
    w.data   = d;
    w.last   = lst;
    due_words.push_back(w);
  endfunction

  // Applies one accepted command word to the shadow store.
  function automatic void sort_insert(logic op, logic [PRIO_W-1:0] pr,
                                      logic [DATA_W-1:0] d);
    int pos;
    if (op == OP_DUMP) begin
      if (held_count == 0) begin
        push_word(ST_EMPTY, '0, '0, 1'b1);
      end else begin
        for (int i = 0; i < held_count; i++)
          push_word(ST_ENTRY, held_prio[i], held_data[i], i == held_count - 1);
      end
    end else if (pr > PRIO_MAX) begin
      push_word(ST_INVALID, '0, '0, 1'b1);
    end else if (held_count >= DEPTH) begin
      push_word(ST_FULL, '0, '0, 1'b1);
    end else begin
      // new entry goes behind every entry of equal or lower priority
      pos = 0;
      while (pos < held_count && held_prio[pos] <= pr) pos++;
      for (int i = held_count; i > pos; i--) begin
        held_prio[i] = held_prio[i-1];
        held_data[i] = held_data[i-1];
      end
      held_prio[pos] = pr;
      held_data[pos] = d;
      held_count++;
    end
  endfunction

  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        held_prio[i] = '0;
        held_data[i] = '0;
      end
      held_count = 0;
      due_words.delete();
    end else begin
      if (out_valid) begin
        if (due_words.size() == 0) begin
          $error("unexpected word: status %0d priority %0d payload 'h%08h last %0b",
                 out_status, out_entry_priority, out_entry_payload, out_last);
          errs++;
        end else begin
          w = due_words.pop_front();
          if (out_status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, out_status);
            errs++;
          end
          if (out_entry_priority !== w.prio) begin
            $error("entry_priority: expected %0d, got %0d", w.prio, out_entry_priority);
            errs++;
          end
          if (out_entry_payload !== w.data) begin
            $error("entry_payload: expected 'h%08h, got 'h%08h", w.data, out_entry_payload);
            errs++;
          end
          if (out_last !== w.last) begin
            $error("last: expected %0b, got %0b", w.last, out_last);
            errs++;
          end
        end
      end
      if (start && !busy)
        sort_insert(in_operation, in_priority_req, in_payload);
    end
    pending <= due_words.size();
  end

endmodule

>>> tb/sv/tb_stable_priority_insert_queue_top.sv
// ----------------------------------------------------------------------------
// tb_stable_priority_insert_queue_top
// Drives insert and dump commands into the priority queue: a directed pass
// over empty, invalid, stable-order and full cases, then random commands in
// phases of differing sender idle rates. Checking is done by spiq_checker.
// ----------------------------------------------------------------------------
module tb_stable_priority_insert_queue_top;
  import spiq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int IDLE_LIMIT = 1000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_operation = OP_INSERT;
  logic [PRIO_W-1:0]        in_priority_req = '0;
  logic signed [DATA_W-1:0] in_payload = '0;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic [PRIO_W-1:0]        out_entry_priority;
  logic signed [DATA_W-1:0] out_entry_payload;
  logic                     out_last;
  int                       fail_count;
  int                       pending;
  int                       idle_pct = 0;
  int                       quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stable_priority_insert_queue_top #(.DEPTH(DEPTH)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_priority_req    (in_priority_req),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_priority (out_entry_priority),
    .out_entry_payload  (out_entry_payload),
    .out_last           (out_last)
  );

  spiq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_priority_req    (in_priority_req),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_priority (out_entry_priority),
    .out_entry_payload  (out_entry_payload),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // hang guard: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb_stable_priority_insert_queue_top failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic op, input logic [PRIO_W-1:0] pr,
                           input logic [DATA_W-1:0] d);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_priority_req <= pr;
    in_payload      <= d;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int pick;
    logic op;
    logic [PRIO_W-1:0] pr;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dump, bad priorities, extremes, equal-priority order
    send_word(OP_DUMP, '0, '0);
    send_word(OP_INSERT, PRIO_MAX + 3'd1, 32'h1234_5678);
    send_word(OP_INSERT, '1, 32'hffff_ffff);
    send_word(OP_INSERT, '0, 32'h8000_0000);
    send_word(OP_INSERT, PRIO_MAX, 32'h7fff_ffff);
    send_word(OP_INSERT, 3'd3, 32'h0000_0000);
    send_word(OP_INSERT, 3'd3, 32'hffff_ffff);
    send_word(OP_INSERT, 3'd3, 32'h0000_0001);
    send_word(OP_INSERT, '0, 32'h0000_0002);
    send_word(OP_INSERT, PRIO_MAX, 32'h0000_0003);
    send_word(OP_DUMP, '1, '1);
    // fill every free slot, then overflow
    for (int k = 0; k < DEPTH - 7; k++)
      send_word(OP_INSERT, 3'($urandom_range(PRIO_MAX)), $urandom);
    send_word(OP_INSERT, 3'd2, 32'hdead_beef);
    send_word(OP_INSERT, '1, 32'h0bad_0bad);
    send_word(OP_DUMP, '0, '0);

    // random phases; results cannot be held off, so only the sender idles
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 72 : (ph == 3) ? 31 : 0;
      for (int k = 0; k < 100; k++) begin
        pick = $urandom_range(99);
        op   = (pick < 30) ? OP_DUMP : OP_INSERT;
        pr   = (pick % 8 == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(PRIO_MAX));
        send_word(op, pr, $urandom);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_stable_priority_insert_queue_top passed");
    else
      $display("tb_stable_priority_insert_queue_top failed");
    $finish;
  end

endmodule
